### src/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg: shared constants for the group-order scalar multiplier
// Group order L, its small multiples, and the limb widths used by the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package smm_pkg;

    localparam int OPND_W = 256;   // operand width
    localparam int RES_W  = 253;   // residue width, holds any value below L
    localparam int SUM_W  = 255;   // 2*r + b, below 3L
    localparam int NUM_PRE = 4;    // pre-reduction cells for the b operand

    typedef logic [OPND_W-1:0] opnd_t;
    typedef logic [RES_W-1:0]  res_t;
    typedef logic [SUM_W-1:0]  sum_t;

    localparam res_t ORDER =
        253'h1000000000000000000000000000000014def9dea2f79cd65812631a5cf5d3ed;

    // Multiples 8L, 4L, 2L, L for the pre-reduction of b (b < 16L)
    localparam opnd_t PRE_MULT [NUM_PRE] = '{
        {ORDER, 3'b000},
        {1'b0, ORDER, 2'b00},
        {2'b00, ORDER, 1'b0},
        {3'b000, ORDER}
    };

    localparam sum_t ORDER_X1 = {2'b00, ORDER};
    localparam sum_t ORDER_X2 = {1'b0, ORDER, 1'b0};

endpackage

`default_nettype wire

### src/smm_reduce_cell.sv
// ----------------------------------------------------------------------------
// smm_reduce_cell: one compare-and-subtract step of the b pre-reduction
// Subtracts a fixed multiple of L when the value is at least that multiple.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_reduce_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          valid_in,
    input  wire smm_pkg::opnd_t mult,
    input  wire smm_pkg::opnd_t a_in,
    input  wire smm_pkg::opnd_t x_in,
    output logic               valid_out,
    output smm_pkg::opnd_t     a_out,
    output smm_pkg::opnd_t     x_out
);
    import smm_pkg::*;

    logic  valid_reg;
    opnd_t a_reg;
    opnd_t x_reg;
    opnd_t x_next;

    // Drop one multiple of L if it fits
    always_comb
    begin
        if (x_in >= mult)
        begin
            x_next = x_in - mult;
        end
        else
        begin
            x_next = x_in;
        end
    end

    // Advance the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (adv && valid_in)
        begin
            a_reg <= a_in;
            x_reg <= x_next;
        end
    end

    assign valid_out = valid_reg;
    assign a_out     = a_reg;
    assign x_out     = x_reg;

endmodule

`default_nettype wire

### src/smm_mac_cell.sv
// ----------------------------------------------------------------------------
// smm_mac_cell: one bit step of the interleaved modular multiplication
// Computes r = 2r + a_bit * b mod L and shifts the next bit of a to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_mac_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          valid_in,
    input  wire smm_pkg::res_t  r_in,
    input  wire smm_pkg::opnd_t a_in,
    input  wire smm_pkg::res_t  b_in,
    output logic               valid_out,
    output smm_pkg::res_t      r_out,
    output smm_pkg::opnd_t     a_out,
    output smm_pkg::res_t      b_out
);
    import smm_pkg::*;

    logic  valid_reg;
    res_t  r_reg;
    opnd_t a_reg;
    res_t  b_reg;
    sum_t  sum;
    res_t  r_next;

    // Double, add b when the bit is set, fold back below L
    always_comb
    begin
        sum = {1'b0, r_in, 1'b0} + (a_in[OPND_W-1] ? {2'b00, b_in} : '0);
        if (sum >= ORDER_X2)
        begin
            r_next = RES_W'(sum - ORDER_X2);
        end
        else if (sum >= ORDER_X1)
        begin
            r_next = RES_W'(sum - ORDER_X1);
        end
        else
        begin
            r_next = RES_W'(sum);
        end
    end

    // Advance the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (adv && valid_in)
        begin
            r_reg <= r_next;
            a_reg <= {a_in[OPND_W-2:0], 1'b0};
            b_reg <= b_in;
        end
    end

    assign valid_out = valid_reg;
    assign r_out     = r_reg;
    assign a_out     = a_reg;
    assign b_out     = b_reg;

    // Residue stays fully reduced
    assert property (@(posedge clk) disable iff (!rst_n) valid_reg |-> (r_reg < ORDER))
        else $error("mac cell residue not below L");

endmodule

`default_nettype wire

### src/scalar_mul_mod_group_order.sv
// ----------------------------------------------------------------------------
// scalar_mul_mod_group_order: (a * b) mod L for the ed25519 group order
// A row of four reduction cells brings b below L, then a row of 256 cells
// forms the product one bit of a per cell, most significant bit first.
// ----------------------------------------------------------------------------
//   channel | handshake             | payload
//   input   | in_valid / in_stall   | a_word0..3, b_word0..3 (64 bits each)
//   output  | out_valid / out_stall | product_word0..2 (64), product_word3 (61)
//
// One item enters per cycle while the output is not stalled; each passes through 4
// reduction cells and then 256 multiply cells, one register each, to the result.
// The length of the multiply row is set by the width of a, one bit of a per cell.
// Reset clears only the valid flags; the cells need no clearing pass.
// A stalled result freezes the whole row; in_stall rises only then.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_mul_mod_group_order (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] a_word0,
    input  wire logic [63:0] a_word1,
    input  wire logic [63:0] a_word2,
    input  wire logic [63:0] a_word3,
    input  wire logic [63:0] b_word0,
    input  wire logic [63:0] b_word1,
    input  wire logic [63:0] b_word2,
    input  wire logic [63:0] b_word3,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      product_word0,
    output logic [63:0]      product_word1,
    output logic [63:0]      product_word2,
    output logic [60:0]      product_word3
);
    import smm_pkg::*;

    localparam int NUM_BITS = OPND_W;

    logic  adv;
    logic  pre_valid [NUM_PRE+1];
    opnd_t pre_a     [NUM_PRE+1];
    opnd_t pre_x     [NUM_PRE+1];
    logic  mac_valid [NUM_BITS+1];
    res_t  mac_r     [NUM_BITS+1];
    opnd_t mac_a     [NUM_BITS+1];
    res_t  mac_b     [NUM_BITS+1];

    // Hold the whole row while a result waits on a stalled output
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    assign pre_valid[0] = in_valid;
    assign pre_a[0]     = {a_word3, a_word2, a_word1, a_word0};
    assign pre_x[0]     = {b_word3, b_word2, b_word1, b_word0};

    // Reduce b below L
    for (genvar i = 0; i < NUM_PRE; i++)
    begin : g_pre
        smm_reduce_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .valid_in  (pre_valid[i]),
            .mult      (PRE_MULT[i]),
            .a_in      (pre_a[i]),
            .x_in      (pre_x[i]),
            .valid_out (pre_valid[i+1]),
            .a_out     (pre_a[i+1]),
            .x_out     (pre_x[i+1])
        );
    end

    assign mac_valid[0] = pre_valid[NUM_PRE];
    assign mac_r[0]     = '0;
    assign mac_a[0]     = pre_a[NUM_PRE];
    assign mac_b[0]     = pre_x[NUM_PRE][RES_W-1:0];

    // Multiply, one bit of a per cell
    for (genvar i = 0; i < NUM_BITS; i++)
    begin : g_mac
        smm_mac_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .valid_in  (mac_valid[i]),
            .r_in      (mac_r[i]),
            .a_in      (mac_a[i]),
            .b_in      (mac_b[i]),
            .valid_out (mac_valid[i+1]),
            .r_out     (mac_r[i+1]),
            .a_out     (mac_a[i+1]),
            .b_out     (mac_b[i+1])
        );
    end

    // Last cell register is the output register
    assign out_valid     = mac_valid[NUM_BITS];
    assign product_word0 = mac_r[NUM_BITS][63:0];
    assign product_word1 = mac_r[NUM_BITS][127:64];
    assign product_word2 = mac_r[NUM_BITS][191:128];
    assign product_word3 = mac_r[NUM_BITS][RES_W-1:192];

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output back-pressure");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({product_word3, product_word2, product_word1, product_word0}
                       < ORDER))
        else $error("result not reduced below L");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(mac_r[NUM_BITS]))
        else $error("frozen row changed its result");

endmodule

`default_nettype wire

### test/scalar_mul_mod_group_order_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scalar_mul_mod_group_order_tb: product modulo the ed25519 group order
// Sends pairs of 256-bit scalars through the valid/stall channel. Each result
// is checked against a product modulo L that the bench forms itself, from a
// full 512-bit multiply and a division. Sender bursts and receiver stalls are
// random.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_mul_mod_group_order_tb;

    import smm_pkg::*;

    localparam int LATENCY = 260;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [63:0] w0;
        logic [63:0] w1;
        logic [63:0] w2;
        logic [60:0] w3;
    } product_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] a_word0, a_word1, a_word2, a_word3;
    logic [63:0] b_word0, b_word1, b_word2, b_word3;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] product_word0, product_word1, product_word2;
    logic [60:0] product_word3;

    product_t    pending_products[$];
    int          error_count;
    int          sent_count;
    int          checked_count;
    longint      cycle_count;
    int          stall_mode;

    scalar_mul_mod_group_order u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .a_word0       (a_word0),
        .a_word1       (a_word1),
        .a_word2       (a_word2),
        .a_word3       (a_word3),
        .b_word0       (b_word0),
        .b_word1       (b_word1),
        .b_word2       (b_word2),
        .b_word3       (b_word3),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .product_word0 (product_word0),
        .product_word1 (product_word1),
        .product_word2 (product_word2),
        .product_word3 (product_word3)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Form (a * b) mod L from the exact product
    function automatic product_t mod_order_product(logic [255:0] a, logic [255:0] b);
        logic [511:0] full;
        logic [511:0] rem;
        product_t     r;
        full = {256'd0, a} * {256'd0, b};
        rem  = full % {259'd0, ORDER};
        r.w0 = rem[63:0];
        r.w1 = rem[127:64];
        r.w2 = rem[191:128];
        r.w3 = rem[252:192];
        return r;
    endfunction

    function automatic logic [255:0] rand_scalar();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    // Send one item, hold until accepted, then maybe gap
    task automatic send_pair(logic [255:0] a, logic [255:0] b, bit allow_gap);
        int gap;
        in_valid <= 1'b1;
        a_word0 <= a[63:0];    a_word1 <= a[127:64];
        a_word2 <= a[191:128]; a_word3 <= a[255:192];
        b_word0 <= b[63:0];    b_word1 <= b[127:64];
        b_word2 <= b[191:128]; b_word3 <= b[255:192];
        pending_products.push_back(mod_order_product(a, b));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
        if (allow_gap && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic idle_sender();
        in_valid <= 1'b0;
    endtask

    // Extremes, zero operands, values at and around L
    task automatic test_directed();
        logic [255:0] ones;
        logic [255:0] ord;
        ones = '1;
        ord  = {3'b000, ORDER};
        send_pair('0, '0, 0);
        send_pair('0, ones, 0);
        send_pair(ones, '0, 0);
        send_pair(ones, ones, 0);
        send_pair(256'd1, 256'd1, 0);
        send_pair(256'd1, ones, 0);
        send_pair(ord, 256'd1, 0);
        send_pair(ord - 1, ord - 1, 0);
        send_pair(ord + 1, ord + 1, 0);
        send_pair(ord, ones, 0);
        send_pair(ord << 3, ord << 3, 0);
        send_pair(256'd1 << 255, 256'd1 << 252, 0);
        send_pair(ord - 1, 256'd2, 0);
        send_pair({4{64'hAAAA_AAAA_AAAA_AAAA}}, {4{64'h5555_5555_5555_5555}}, 0);
        send_pair({4{64'h5555_5555_5555_5555}}, {4{64'hAAAA_AAAA_AAAA_AAAA}}, 0);
        idle_sender();
    endtask

    // Random operands, mostly full width, some near L or sparse
    task automatic test_random(int count);
        logic [255:0] a;
        logic [255:0] b;
        for (int i = 0; i < count; i++)
        begin
            a = rand_scalar();
            b = rand_scalar();
            case ($urandom_range(0, 9))
                0: a = {3'b000, ORDER} - $urandom_range(0, 3);
                1: b = {3'b000, ORDER} + $urandom_range(0, 3);
                2: a = a >> $urandom_range(0, 255);
                3: b = b >> $urandom_range(0, 255);
                default: ;
            endcase
            send_pair(a, b, 1);
        end
        idle_sender();
    endtask

    // Receiver stall pattern: free, light, heavy phases
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if ($urandom_range(0, 199) == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 7) == 0);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        product_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_products.size() == 0)
            begin
                $display("%0t: result with nothing expected: %h %h %h %h", $time,
                         product_word3, product_word2, product_word1, product_word0);
                error_count++;
            end
            else
            begin
                want = pending_products.pop_front();
                checked_count++;
                if (product_word0 !== want.w0)
                begin
                    $display("%0t: product_word0 expected %h actual %h", $time,
                             want.w0, product_word0);
                    error_count++;
                end
                if (product_word1 !== want.w1)
                begin
                    $display("%0t: product_word1 expected %h actual %h", $time,
                             want.w1, product_word1);
                    error_count++;
                end
                if (product_word2 !== want.w2)
                begin
                    $display("%0t: product_word2 expected %h actual %h", $time,
                             want.w2, product_word2);
                    error_count++;
                end
                if (product_word3 !== want.w3)
                begin
                    $display("%0t: product_word3 expected %h actual %h", $time,
                             want.w3, product_word3);
                    error_count++;
                end
            end
        end
    end

    // Count cycles and end the run at the limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        error_count   = 0;
        sent_count    = 0;
        checked_count = 0;
        cycle_count   = 0;
        stall_mode    = 0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        a_word0 = '0; a_word1 = '0; a_word2 = '0; a_word3 = '0;
        b_word0 = '0; b_word1 = '0; b_word2 = '0; b_word3 = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(1800);

        // Drain, then let the row settle
        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);

        $display("sent %0d operand pairs, checked %0d products", sent_count, checked_count);
        $display("covered zero, all-ones, near-L and random operands under stalls");
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
